// ===== design/triangle_grid_mesh_indices_macros.svh =====
// Assertion macros used by the checker file of the triangle mesh index block.
// No dependencies.
`ifndef TRIANGLE_GRID_MESH_INDICES_MACROS_SVH
`define TRIANGLE_GRID_MESH_INDICES_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TGMI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TGMI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tgmi_pkg.sv =====
// Shared types and helpers for the triangle mesh index generator.
// No dependencies; used by tgmi_step and the top level.
`default_nettype none

package tgmi_pkg;

  localparam int unsigned DivW    = 8;
  localparam int unsigned CursorW = 9;
  localparam int unsigned BaseW   = 17;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRows    = 2'd1;

  typedef struct packed {
    logic [DivW-1:0]    row;
    logic [CursorW-1:0] top_cur;
    logic [CursorW-1:0] bot_cur;
    logic [BaseW-1:0]   top_base;
    logic [BaseW-1:0]   bot_base;
    logic [CountW-1:0]  tri_cnt;
  } walk_t;

  typedef struct packed {
    logic [IndexW-1:0] index_a;
    logic [IndexW-1:0] index_b;
    logic [IndexW-1:0] index_c;
    logic [CountW-1:0] triangle_number;
    logic              last_triangle;
    logic              empty_mesh;
  } result_t;

  // Walk state at triangle zero for a given column count
  function automatic walk_t walk_init(input logic [DivW-1:0] cols);
    walk_t w;
    w          = '0;
    w.bot_base = {{(BaseW-DivW){1'b0}}, cols} + BaseW'(1);
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/tgmi_step.sv =====
// One walk step: next triangle of the current strip and the updated walk state.
// Depends on tgmi_pkg.
`default_nettype none

module tgmi_step (
  input  logic [tgmi_pkg::DivW-1:0] cols_i,
  input  logic [tgmi_pkg::DivW-1:0] rows_i,
  input  logic                      empty_i,
  input  tgmi_pkg::walk_t           cur_i,
  output tgmi_pkg::result_t         res_o,
  output tgmi_pkg::walk_t           nxt_o
);
  import tgmi_pkg::*;

  logic               odd;
  logic [CursorW-1:0] top_n, bot_n;
  logic [CursorW:0]   top_x, bot_x, last_x;
  logic [CursorW+1:0] tu, bu;
  logic               can_top, can_bot, adv_top;
  logic [BaseW-1:0]   a_full, b_full, c_full;
  logic [CursorW-1:0] top_cur_n, bot_cur_n;
  logic               strip_done, last;

  always_comb begin
    odd    = cur_i.row[0];
    top_n  = {1'b0, cols_i} + CursorW'(1) + {{(CursorW-1){1'b0}}, odd};
    bot_n  = {1'b0, cols_i} + CursorW'(1) + {{(CursorW-1){1'b0}}, ~odd};
    top_x  = {1'b0, cur_i.top_cur} + (CursorW+1)'(1);
    bot_x  = {1'b0, cur_i.bot_cur} + (CursorW+1)'(1);
    last_x = {2'b00, cols_i} + (CursorW+1)'(1);
    can_top = top_x < {1'b0, top_n};
    can_bot = bot_x < {1'b0, bot_n};

    // doubled u numerators; odd rows are offset by half a step, clamped at the end
    if (!odd) begin
      tu = {top_x, 1'b0};
      bu = (bot_x == last_x) ? {2'b00, cols_i, 1'b0} : ({bot_x, 1'b0} - (CursorW+2)'(1));
    end else begin
      tu = (top_x == last_x) ? {2'b00, cols_i, 1'b0} : ({top_x, 1'b0} - (CursorW+2)'(1));
      bu = {bot_x, 1'b0};
    end

    // on a tie the shorter row (the even one) goes first
    if (!can_bot)      adv_top = 1'b1;
    else if (!can_top) adv_top = 1'b0;
    else if (tu != bu) adv_top = tu < bu;
    else               adv_top = ~odd;

    a_full = cur_i.top_base + {{(BaseW-CursorW){1'b0}}, cur_i.top_cur};
    c_full = cur_i.bot_base + {{(BaseW-CursorW){1'b0}}, cur_i.bot_cur};
    b_full = adv_top ? (a_full + BaseW'(1)) : (c_full + BaseW'(1));

    top_cur_n = adv_top ? (cur_i.top_cur + CursorW'(1)) : cur_i.top_cur;
    bot_cur_n = adv_top ? cur_i.bot_cur : (cur_i.bot_cur + CursorW'(1));

    strip_done = (({1'b0, top_cur_n} + (CursorW+1)'(1)) >= {1'b0, top_n}) &&
                 (({1'b0, bot_cur_n} + (CursorW+1)'(1)) >= {1'b0, bot_n});
    last = strip_done && (({1'b0, cur_i.row} + (DivW+1)'(1)) >= {1'b0, rows_i});

    res_o                 = '0;
    nxt_o                 = cur_i;
    if (empty_i) begin
      res_o.empty_mesh = 1'b1;
    end else begin
      res_o.index_a         = a_full[IndexW-1:0];
      res_o.index_b         = b_full[IndexW-1:0];
      res_o.index_c         = c_full[IndexW-1:0];
      res_o.triangle_number = cur_i.tri_cnt;
      res_o.last_triangle   = last;

      nxt_o.top_cur = top_cur_n;
      nxt_o.bot_cur = bot_cur_n;
      nxt_o.tri_cnt = cur_i.tri_cnt + CountW'(1);
      if (last) begin
        nxt_o = walk_init(cols_i);
      end else if (strip_done) begin
        nxt_o.row      = cur_i.row + DivW'(1);
        nxt_o.top_cur  = '0;
        nxt_o.bot_cur  = '0;
        nxt_o.top_base = cur_i.bot_base;
        nxt_o.bot_base = cur_i.bot_base + {{(BaseW-CursorW){1'b0}}, bot_n};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/triangle_grid_mesh_indices.sv =====
// Triangle lattice index generator: one triangle per accepted item, the result
// registered at the accepting edge; throughput 1 item per cycle while the sink takes
// results, set by the combinational walk step feeding the output register.
// Reset (async, active low): 1 x 1 divisions, walk at triangle zero, no result pending.
// Depends on tgmi_pkg and tgmi_step.
`default_nettype none

module triangle_grid_mesh_indices #(
  parameter int unsigned MAX_VERTICES  = 32'd65536,
  parameter int unsigned MAX_DIVISIONS = 32'd255
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [tgmi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tgmi_pkg::DivW-1:0]    cfg_data_i,
  // input item channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  // result item channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tgmi_pkg::IndexW-1:0]  index_a_o,
  output logic [tgmi_pkg::IndexW-1:0]  index_b_o,
  output logic [tgmi_pkg::IndexW-1:0]  index_c_o,
  output logic [tgmi_pkg::CountW-1:0]  triangle_number_o,
  output logic                         last_triangle_o,
  output logic                         empty_mesh_o
);
  import tgmi_pkg::*;

  // Empty flag from the vertex count: even rows cols+1, odd rows cols+2 vertices.
  // All operands are widened to the full product width before multiplying.
  function automatic logic calc_empty(input logic [DivW-1:0] cols,
                                      input logic [DivW-1:0] rows);
    logic [2*DivW+1:0]  even_rows, odd_rows, col_even, col_odd;
    logic [2*DivW+1:0]  verts;
    even_rows = ({{(DivW+2){1'b0}}, rows} + (2*DivW+2)'(2)) >> 1;
    odd_rows  = ({{(DivW+2){1'b0}}, rows} + (2*DivW+2)'(1)) >> 1;
    col_even  = {{(DivW+2){1'b0}}, cols} + (2*DivW+2)'(1);
    col_odd   = {{(DivW+2){1'b0}}, cols} + (2*DivW+2)'(2);
    verts     = (col_even * even_rows) + (col_odd * odd_rows);
    return (cols == '0) || (rows == '0) ||
           ({{(32-DivW){1'b0}}, cols} > MAX_DIVISIONS) ||
           ({{(32-DivW){1'b0}}, rows} > MAX_DIVISIONS) ||
           ({{(32-2*DivW-2){1'b0}}, verts} > MAX_VERTICES);
  endfunction

  logic [DivW-1:0] cols_q, cols_d, rows_q, rows_d;
  logic            empty_q;
  walk_t           walk_q, walk_cur, walk_nxt;
  result_t         res_q, res_step;
  logic            out_valid_q;
  logic            in_fire;

  // The output register frees up in the same cycle it is drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegColumns: cols_d = cfg_data_i;
        RegRows:    rows_d = cfg_data_i;
        default:    ;
      endcase
    end
  end

  // A restart item starts over at triangle zero before its triangle is built.
  assign walk_cur = restart_i ? walk_init(cols_q) : walk_q;

  tgmi_step u_step (
    .cols_i  (cols_q),
    .rows_i  (rows_q),
    .empty_i (empty_q),
    .cur_i   (walk_cur),
    .res_o   (res_step),
    .nxt_o   (walk_nxt)
  );

  // Sizes, empty flag and walk state. The empty flag is precomputed from the
  // new sizes, so the step path only sees a flop. Any register write restarts
  // the walk; writes to indexes past the list change nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= DivW'(1);
      rows_q  <= DivW'(1);
      empty_q <= 1'b0;
      walk_q  <= walk_init(DivW'(1));
    end else begin
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      empty_q <= calc_empty(cols_d, rows_d);
      if (cfg_we_i && (cfg_index_i == RegColumns || cfg_index_i == RegRows)) begin
        walk_q <= walk_init(cols_d);
      end else if (in_fire) begin
        walk_q <= walk_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_step;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign index_a_o         = res_q.index_a;
  assign index_b_o         = res_q.index_b;
  assign index_c_o         = res_q.index_c;
  assign triangle_number_o = res_q.triangle_number;
  assign last_triangle_o   = res_q.last_triangle;
  assign empty_mesh_o      = res_q.empty_mesh;

endmodule

`default_nettype wire

// ===== design/tgmi_checker.sv =====
// Port-level checks of the triangle mesh index block, bound to the top level.
// Depends on tgmi_pkg and triangle_grid_mesh_indices_macros.svh.
`default_nettype none
`include "triangle_grid_mesh_indices_macros.svh"

module tgmi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [tgmi_pkg::IndexW-1:0]  index_a_o,
  input logic [tgmi_pkg::IndexW-1:0]  index_b_o,
  input logic [tgmi_pkg::IndexW-1:0]  index_c_o,
  input logic [tgmi_pkg::CountW-1:0]  triangle_number_o,
  input logic                         last_triangle_o,
  input logic                         empty_mesh_o
);
  import tgmi_pkg::*;

  logic [IndexW-1:0] a_inc, c_inc;
  assign a_inc = index_a_o + IndexW'(1);
  assign c_inc = index_c_o + IndexW'(1);

  `TGMI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(index_a_o) && $stable(index_b_o) && $stable(index_c_o) &&
    $stable(triangle_number_o) && $stable(last_triangle_o) && $stable(empty_mesh_o),
    "stalled item changed")
  `TGMI_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, in_valid_i && in_ready_o,
    out_valid_o, "accepted item gave no result")
  `TGMI_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_o && empty_mesh_o,
    index_a_o == '0 && index_b_o == '0 && index_c_o == '0 &&
    triangle_number_o == '0 && !last_triangle_o, "empty mesh item not zero")
  `TGMI_ASSERT_NOW(a_b_neighbor, clk_i, rst_ni, out_valid_o && !empty_mesh_o,
    index_b_o == a_inc || index_b_o == c_inc, "second index not next to a cursor")

endmodule

bind triangle_grid_mesh_indices tgmi_checker u_tgmi_checker (.*);

`default_nettype wire

// ===== dv/triangle_grid_mesh_indices_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for triangle_grid_mesh_indices: walks lattice meshes of many sizes
// and checks every emitted triangle against a scoreboard that predicts the walk.
// Depends on tgmi_pkg and the RTL of the block only.

module triangle_grid_mesh_indices_tb;
  import tgmi_pkg::*;

  localparam int unsigned MaxVertices  = 65536;
  localparam int unsigned MaxDivisions = 255;
  localparam int unsigned BaseMask     = (1 << BaseW) - 1;
  localparam int unsigned CountMask    = (1 << CountW) - 1;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomItems  = 1100;
  localparam int unsigned SinkParkLen  = 300;

  // Register indexes past the end of the register list; writes to them are dropped
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  // Predicts the triangle walk and holds the triangles still owed by the block
  class tri_walk_scoreboard;
    int unsigned cols;
    int unsigned rows;
    int unsigned row_pos;
    int unsigned top_cur;
    int unsigned bot_cur;
    int unsigned top_base;
    int unsigned bot_base;
    int unsigned tri_cnt;
    result_t     expected_tris[$];
    int unsigned failures;

    function new();
      cols     = 1;
      rows     = 1;
      failures = 0;
      restart_walk();
    endfunction

    function void restart_walk();
      row_pos  = 0;
      top_cur  = 0;
      bot_cur  = 0;
      top_base = 0;
      bot_base = (cols + 1) & BaseMask;
      tri_cnt  = 0;
    endfunction

    function bit mesh_empty();
      int unsigned verts;
      if (cols == 0 || rows == 0) return 1'b1;
      if (cols > MaxDivisions || rows > MaxDivisions) return 1'b1;
      // rows+1 vertex rows: even rows hold cols+1 vertices, odd rows cols+2
      verts = (cols + 1) * ((rows + 2) / 2) + (cols + 2) * ((rows + 1) / 2);
      return verts > MaxVertices;
    endfunction

    function int unsigned row_len(input int unsigned y);
      return cols + 1 + (y & 1);
    endfunction

    // Doubled u numerator of vertex x (x >= 1) in row y
    function int unsigned u_numer(input int unsigned y, input int unsigned x);
      if ((y & 1) == 0) return x * 2;
      if (x == cols + 1) return cols * 2;
      return x * 2 - 1;
    endfunction

    function void note_config(input logic [CfgIdxW-1:0] idx, input logic [DivW-1:0] val);
      case (idx)
        RegColumns: cols = val;
        RegRows:    rows = val;
        default:    return;
      endcase
      restart_walk();
    endfunction

    function void note_item(input bit restart);
      result_t     r;
      int unsigned y;
      int unsigned top_n;
      int unsigned bot_n;
      int unsigned tu;
      int unsigned bu;
      bit          adv_top;
      if (restart) restart_walk();
      r = '0;
      if (mesh_empty()) begin
        r.empty_mesh = 1'b1;
        expected_tris.push_back(r);
        return;
      end
      y     = row_pos;
      top_n = row_len(y);
      bot_n = row_len(y + 1);
      if (bot_cur + 1 >= bot_n) begin
        adv_top = 1'b1;
      end else if (top_cur + 1 >= top_n) begin
        adv_top = 1'b0;
      end else begin
        tu = u_numer(y, top_cur + 1);
        bu = u_numer(y + 1, bot_cur + 1);
        // on a tie the shorter row moves first
        adv_top = (tu != bu) ? (tu < bu) : (top_n < bot_n);
      end
      r.index_a = IndexW'(top_base + top_cur);
      r.index_c = IndexW'(bot_base + bot_cur);
      if (adv_top) begin
        r.index_b = IndexW'(top_base + top_cur + 1);
        top_cur++;
      end else begin
        r.index_b = IndexW'(bot_base + bot_cur + 1);
        bot_cur++;
      end
      r.triangle_number = CountW'(tri_cnt);
      tri_cnt = (tri_cnt + 1) & CountMask;
      if (top_cur + 1 >= top_n && bot_cur + 1 >= bot_n) begin
        if (y + 1 >= rows) begin
          r.last_triangle = 1'b1;
          restart_walk();
        end else begin
          row_pos  = y + 1;
          top_cur  = 0;
          bot_cur  = 0;
          top_base = bot_base;
          bot_base = (bot_base + bot_n) & BaseMask;
        end
      end
      expected_tris.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_tris.size();
    endfunction

    function void check_tri(input result_t got);
      result_t want;
      bit      bad;
      if (expected_tris.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected triangle: a=%0d b=%0d c=%0d n=%0d last=%0b empty=%0b",
                   got.index_a, got.index_b, got.index_c, got.triangle_number,
                   got.last_triangle, got.empty_mesh);
        return;
      end
      want = expected_tris.pop_front();
      bad  = (got.index_a !== want.index_a) || (got.index_b !== want.index_b) ||
             (got.index_c !== want.index_c) ||
             (got.triangle_number !== want.triangle_number) ||
             (got.last_triangle !== want.last_triangle) ||
             (got.empty_mesh !== want.empty_mesh);
      if (bad) begin
        failures++;
        if (failures <= MaxReports)
          $display("triangle mismatch: exp a=%0d b=%0d c=%0d n=%0d last=%0b empty=%0b %s",
                   want.index_a, want.index_b, want.index_c, want.triangle_number,
                   want.last_triangle, want.empty_mesh, "|");
        if (failures <= MaxReports)
          $display("                   got a=%0d b=%0d c=%0d n=%0d last=%0b empty=%0b",
                   got.index_a, got.index_b, got.index_c, got.triangle_number,
                   got.last_triangle, got.empty_mesh);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [DivW-1:0]     cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IndexW-1:0]   index_a_o;
  logic [IndexW-1:0]   index_b_o;
  logic [IndexW-1:0]   index_c_o;
  logic [CountW-1:0]   triangle_number_o;
  logic                last_triangle_o;
  logic                empty_mesh_o;

  tri_walk_scoreboard  sb = new();
  result_t             seen_tri;

  // quiet: neither side idles; park_sink: sink holds ready low for a long stretch
  bit                  quiet     = 1'b0;
  bit                  park_sink = 1'b0;
  int unsigned         random_sent = 0;

  always #1 clk_i = ~clk_i;

  triangle_grid_mesh_indices #(
    .MAX_VERTICES  (MaxVertices),
    .MAX_DIVISIONS (MaxDivisions)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .restart_i         (restart_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .index_a_o         (index_a_o),
    .index_b_o         (index_b_o),
    .index_c_o         (index_c_o),
    .triangle_number_o (triangle_number_o),
    .last_triangle_o   (last_triangle_o),
    .empty_mesh_o      (empty_mesh_o)
  );

  // Mostly back-to-back, some short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Observer: all port values are read at the clock edge, before the block's
  // registers and our own nonblocking drives move, so order within a step
  // does not matter. Config writes go to the scoreboard first, then accepted
  // items, then the triangle leaving the block.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_config(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_item(restart_i);
      if (out_valid_o && out_ready_i) begin
        seen_tri = {index_a_o, index_b_o, index_c_o, triangle_number_o,
                    last_triangle_o, empty_mesh_o};
        sb.check_tri(seen_tri);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random ready stalls; one long park on request so the block
  // backs up and stalls its input. One drive of out_ready_i per edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (park_sink) begin
        stall     = SinkParkLen;
        park_sink = 1'b0;
      end else begin
        stall = quiet ? 0 : idle_len();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Offer one item; returns at the edge where it is taken. Valid stays high
  // across back-to-back items and only drops for a gap.
  task automatic send_item(input bit restart);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every owed triangle is out, then let the output
  // register settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write enable is left high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DivW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic set_divisions(input int unsigned cols, input int unsigned rows,
                               input bit stray);
    write_reg(RegColumns, DivW'(cols));
    write_reg(RegRows, DivW'(rows));
    if (stray) write_reg($urandom_range(0, 1) ? RegSpare2 : RegSpare3, DivW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned pick;
    int unsigned cols;
    int unsigned rows;
    int unsigned count;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes are 1 x 1: three triangles, then the walk wraps
    repeat (4) send_item(1'b0);
    send_item(1'b1);

    // Writes past the register list are dropped and must not restart the walk
    drain();
    write_reg(RegSpare2, 8'hFF);
    write_reg(RegSpare3, 8'h00);
    cfg_we_i <= 1'b0;
    repeat (2) send_item(1'b0);

    // Zero columns, then zero rows: empty mesh, restart or not
    drain();
    set_divisions(0, 5, 1'b0);
    send_item(1'b0);
    send_item(1'b1);
    drain();
    set_divisions(4, 0, 1'b0);
    send_item(1'b0);

    // Largest sizes: 255 x 255 is over the vertex limit, 255 x 254 just fits
    drain();
    set_divisions(MaxDivisions, MaxDivisions, 1'b0);
    repeat (2) send_item(1'b0);
    drain();
    set_divisions(MaxDivisions, MaxDivisions - 1, 1'b0);
    repeat (3) send_item(1'b0);
    send_item(1'b1);

    // Small odd-row mesh with a restart part way
    drain();
    set_divisions(2, 3, 1'b0);
    repeat (6) send_item(1'b0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);

    // Random phases: mostly small meshes walked past their wrap point, some
    // empty ones, a few long rows or many rows, rare restarts as noise.
    phase = 0;
    while (random_sent < RandomItems) begin
      drain();
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        cols = $urandom_range(1, 6);
        rows = $urandom_range(1, 6);
      end else if (pick < 85) begin
        cols = $urandom_range(0, 1) ? 0 : $urandom_range(1, 255);
        rows = (cols == 0) ? $urandom_range(0, 255) : 0;
      end else if (pick < 92) begin
        cols = $urandom_range(200, 255);
        rows = $urandom_range(1, 3);
      end else if (pick < 97) begin
        cols = $urandom_range(1, 3);
        rows = $urandom_range(200, 255);
      end else begin
        cols = MaxDivisions;
        rows = MaxDivisions - $urandom_range(0, 1);
      end
      set_divisions(cols, rows, $urandom_range(0, 3) == 0);

      count = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 4) == 0);
      // Early on: one phase with a long sink park while items keep coming
      if (phase == 3) begin
        quiet     = 1'b1;
        park_sink = 1'b1;
        count     = 120;
      end
      for (int unsigned i = 0; i < count; i++) begin
        send_item($urandom_range(0, 31) == 0);
        random_sent++;
        // Sender pause mid-walk until everything owed has come out
        if ((phase == 5 || $urandom_range(0, 199) == 0) && i == count / 2) drain();
      end
      quiet = 1'b0;
      phase++;
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every item behind the longest
  // sender gap and sink stall, plus the long park)
  initial begin : watchdog
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
